// ===== design/vpssb_pkg.sv =====
// Shared definitions for the sphere-bounded Verlet particle step.
// Holds the configuration register index codes and their reset values; no dependencies.
package vpssb_pkg;

    localparam int CFG_IDX_W = 1;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx REG_LIMIT_RADIUS  = 1'd0;
    localparam t_cfg_idx REG_FALL_PER_STEP = 1'd1;

    localparam int LIMIT_RESET = 442368;
    localparam int FALL_RESET  = -182;

endpackage

// ===== design/verlet_particle_step_sphere_bound.sv =====
// Pipelined position-Verlet particle update with a spherical container constraint.
// Depends on vpssb_pkg (register index codes, reset values).
//
// channel | direction | handshake                        | payload (lowest bits first)
// s_axis  | in        | i_s_axis_tvalid/o_s_axis_tready  | pos_x,pos_y,pos_z,prior_x,prior_y,prior_z
// m_axis  | out       | o_m_axis_tvalid/i_m_axis_tready  | next_x..z, kept_x..z, was_clamped, overflowed
// cfg     | in        | i_cfg_we                         | i_cfg_idx, i_cfg_data
//
// One item per cycle while the output is not stalled. Stages in order: three front
// stages (abs, squares/products, length compare), one stage per root bit of the square
// root, one rounding-add stage, one stage per quotient bit of the three dividers, then
// clamp select and output.
// Synchronous active-low reset clears all valid bits and loads register defaults.
// A stall at the output freezes the whole pipeline; nothing is dropped or repeated.
module verlet_particle_step_sphere_bound #(
    parameter int POSITION_BITS = 22
) (
    input  logic                                             i_clk,
    input  logic                                             i_rst_n,
    input  logic                                             i_cfg_we,
    input  vpssb_pkg::t_cfg_idx                              i_cfg_idx,
    input  logic [POSITION_BITS-1:0]                         i_cfg_data,
    input  logic                                             i_s_axis_tvalid,
    output logic                                             o_s_axis_tready,
    // pos_x, pos_y, pos_z, prior_x, prior_y, prior_z, zero pad
    input  logic [((6*POSITION_BITS+7)/8)*8-1:0]             i_s_axis_tdata,
    output logic                                             o_m_axis_tvalid,
    input  logic                                             i_m_axis_tready,
    // next_x, next_y, next_z, kept_x, kept_y, kept_z, was_clamped, overflowed, zero pad
    output logic [((6*POSITION_BITS+2+7)/8)*8-1:0]           o_m_axis_tdata
);
    import vpssb_pkg::*;

    localparam int P     = POSITION_BITS;
    localparam int NR    = P + 1;
    localparam int RW    = 2 * P + 2;
    localparam int RMW   = NR + 3;
    localparam int OUT_W = ((6 * P + 2 + 7) / 8) * 8;

    typedef logic [2:0][P-1:0] t_vec;
    typedef struct packed {
        t_vec p;
        t_vec pr;
        logic clamp;
    } t_base;

    logic               r_lim_low;
    logic [P-2:0]       r_lim;
    logic [P-1:0]       r_fall;
    logic               w_adv;

    assign r_lim_low = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim  <= (P-1)'(LIMIT_RESET);
            r_fall <= P'(FALL_RESET);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_LIMIT_RADIUS:  r_lim  <= i_cfg_data[P-2:0];
                REG_FALL_PER_STEP: r_fall <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- stage A: unpack, magnitudes
    logic  r_a_vld;
    t_base r_a_base, n_a_base;
    t_vec  r_a_mag, n_a_mag;

    always_comb begin
        n_a_base.clamp = 1'b0;
        for (int i = 0; i < 3; i++) begin
            n_a_base.p[i]  = i_s_axis_tdata[i*P +: P];
            n_a_base.pr[i] = i_s_axis_tdata[(3+i)*P +: P];
            n_a_mag[i]     = n_a_base.p[i][P-1] ? (P'(0) - n_a_base.p[i]) : n_a_base.p[i];
        end
    end

    // ---------------- stage B: squares and scale products
    logic                     r_b_vld;
    t_base                    r_b_base;
    logic [2:0][2*P-1:0]      r_b_sq, n_b_sq;
    logic [2:0][2*P-2:0]      r_b_prod, n_b_prod;
    logic [2*P-3:0]           r_b_lim2, n_b_lim2;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_b_sq[i]   = {{P{1'b0}}, r_a_mag[i]} * {{P{1'b0}}, r_a_mag[i]};
            n_b_prod[i] = {{(P-1){1'b0}}, r_a_mag[i]} * {{P{1'b0}}, r_lim};
        end
        n_b_lim2 = {{(P-1){1'b0}}, r_lim} * {{(P-1){1'b0}}, r_lim};
    end

    // ---------------- stage C: squared length and limit test
    logic                r_c_vld;
    t_base               r_c_base, n_c_base;
    logic [2:0][2*P-2:0] r_c_prod;
    logic [RW-1:0]       r_c_len2, n_c_len2;

    assign n_c_len2 = RW'(r_b_sq[0]) + RW'(r_b_sq[1]) + RW'(r_b_sq[2]);

    always_comb begin
        n_c_base       = r_b_base;
        n_c_base.clamp = n_c_len2 > RW'(r_b_lim2);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
        end else if (w_adv) begin
            r_a_vld <= i_s_axis_tvalid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_a_base       <= n_a_base;
            r_a_mag        <= n_a_mag;
            r_b_base       <= r_a_base;
            r_b_sq         <= n_b_sq;
            r_b_prod       <= n_b_prod;
            r_b_lim2       <= n_b_lim2;
            r_c_base       <= n_c_base;
            r_c_prod       <= r_b_prod;
            r_c_len2       <= n_c_len2;
        end
    end

    // ---------------- square root, one root bit per stage
    logic                r_q_vld  [NR];
    t_base               r_q_base [NR];
    logic [2:0][2*P-2:0] r_q_prod [NR];
    logic [RW-1:0]       r_q_rad  [NR];
    logic [RMW-1:0]      r_q_rem  [NR];
    logic [NR-1:0]       r_q_root [NR];

    for (genvar j = 0; j < NR; j++) begin : g_sqrt
        logic                w_vld;
        t_base               w_base;
        logic [2:0][2*P-2:0] w_prod;
        logic [RW-1:0]       w_rad;
        logic [RMW-1:0]      w_rem, w_rem2, w_trial;
        logic [NR-1:0]       w_root;
        logic                w_ge;

        always_comb begin
            if (j == 0) begin
                w_vld  = r_c_vld;
                w_base = r_c_base;
                w_prod = r_c_prod;
                w_rad  = r_c_len2;
                w_rem  = '0;
                w_root = '0;
            end else begin
                w_vld  = r_q_vld[(j == 0) ? 0 : j-1];
                w_base = r_q_base[(j == 0) ? 0 : j-1];
                w_prod = r_q_prod[(j == 0) ? 0 : j-1];
                w_rad  = r_q_rad[(j == 0) ? 0 : j-1];
                w_rem  = r_q_rem[(j == 0) ? 0 : j-1];
                w_root = r_q_root[(j == 0) ? 0 : j-1];
            end
            w_rem2  = {w_rem[RMW-3:0], w_rad[RW-1:RW-2]};
            w_trial = {1'b0, w_root, 2'b01};
            w_ge    = w_rem2 >= w_trial;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_q_vld[j] <= 1'b0;
            end else if (w_adv) begin
                r_q_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_q_base[j] <= w_base;
                r_q_prod[j] <= w_prod;
                r_q_rad[j]  <= w_rad << 2;
                r_q_rem[j]  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
                r_q_root[j] <= {w_root[NR-2:0], w_ge};
            end
        end
    end

    // ---------------- stage D: rounded numerators
    logic              r_n_vld;
    t_base             r_n_base;
    logic [NR-1:0]     r_n_len;
    logic [2:0][2*P-1:0] r_n_num;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_vld <= 1'b0;
        end else if (w_adv) begin
            r_n_vld <= r_q_vld[NR-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_n_base <= r_q_base[NR-1];
            r_n_len  <= r_q_root[NR-1];
            for (int i = 0; i < 3; i++) begin
                r_n_num[i] <= (2*P)'(r_q_prod[NR-1][i]) + (2*P)'(r_q_root[NR-1][NR-1:1]);
            end
        end
    end

    // ---------------- three dividers, one quotient bit per stage
    logic               r_d_vld  [P];
    t_base              r_d_base [P];
    logic [NR-1:0]      r_d_len  [P];
    logic [2:0][NR-1:0] r_d_rem  [P];
    t_vec               r_d_low  [P];
    t_vec               r_d_quo  [P];

    for (genvar j = 0; j < P; j++) begin : g_div
        logic               w_vld;
        t_base              w_base;
        logic [NR-1:0]      w_len;
        logic [2:0][NR-1:0] w_rem, n_rem;
        t_vec               w_low, w_quo, n_quo;
        logic [NR:0]        w_t [3];
        logic [2:0]         w_ge;

        always_comb begin
            if (j == 0) begin
                w_vld  = r_n_vld;
                w_base = r_n_base;
                w_len  = r_n_len;
                for (int i = 0; i < 3; i++) begin
                    w_rem[i] = {1'b0, r_n_num[i][2*P-1:P]};
                    w_low[i] = r_n_num[i][P-1:0];
                end
                w_quo = '0;
            end else begin
                w_vld  = r_d_vld[(j == 0) ? 0 : j-1];
                w_base = r_d_base[(j == 0) ? 0 : j-1];
                w_len  = r_d_len[(j == 0) ? 0 : j-1];
                w_rem  = r_d_rem[(j == 0) ? 0 : j-1];
                w_low  = r_d_low[(j == 0) ? 0 : j-1];
                w_quo  = r_d_quo[(j == 0) ? 0 : j-1];
            end
            for (int i = 0; i < 3; i++) begin
                w_t[i]   = {w_rem[i], w_low[i][P-1]};
                w_ge[i]  = w_t[i] >= {1'b0, w_len};
                n_rem[i] = w_ge[i] ? NR'(w_t[i] - {1'b0, w_len}) : w_t[i][NR-1:0];
                n_quo[i] = {w_quo[i][P-2:0], w_ge[i]};
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[j] <= 1'b0;
            end else if (w_adv) begin
                r_d_vld[j] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_d_base[j] <= w_base;
                r_d_len[j]  <= w_len;
                r_d_rem[j]  <= n_rem;
                for (int i = 0; i < 3; i++) begin
                    r_d_low[j][i] <= w_low[i] << 1;
                end
                r_d_quo[j]  <= n_quo;
            end
        end
    end

    // ---------------- stage E: constrained position
    logic  r_e_vld;
    t_base r_e_base;
    t_vec  r_e_kept, n_e_kept;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!r_d_base[P-1].clamp) begin
                n_e_kept[i] = r_d_base[P-1].p[i];
            end else if (r_d_base[P-1].p[i][P-1]) begin
                n_e_kept[i] = P'(0) - r_d_quo[P-1][i];
            end else begin
                n_e_kept[i] = r_d_quo[P-1][i];
            end
        end
    end

    // ---------------- stage F: Verlet step and saturation
    logic        r_f_vld;
    t_vec        r_f_next, n_f_next;
    t_vec        r_f_kept;
    logic        r_f_clamp;
    logic        r_f_ovf, n_f_ovf;
    logic [P+2:0] w_v [3];

    always_comb begin
        n_f_ovf = 1'b0;
        for (int i = 0; i < 3; i++) begin
            w_v[i] = {{2{r_e_kept[i][P-1]}}, r_e_kept[i], 1'b0}
                   - {{3{r_e_base.pr[i][P-1]}}, r_e_base.pr[i]}
                   + ((i == 1) ? {{3{r_fall[P-1]}}, r_fall} : (P+3)'(0));
            if (w_v[i][P+2:P-1] != {4{w_v[i][P+2]}}) begin
                n_f_ovf     = 1'b1;
                n_f_next[i] = w_v[i][P+2] ? {1'b1, {(P-1){1'b0}}} : {1'b0, {(P-1){1'b1}}};
            end else begin
                n_f_next[i] = w_v[i][P-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
        end else if (w_adv) begin
            r_e_vld <= r_d_vld[P-1];
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_base  <= r_d_base[P-1];
            r_e_kept  <= n_e_kept;
            r_f_next  <= n_f_next;
            r_f_kept  <= r_e_kept;
            r_f_clamp <= r_e_base.clamp;
            r_f_ovf   <= n_f_ovf;
        end
    end

    assign w_adv           = !r_f_vld || i_m_axis_tready;
    assign o_s_axis_tready = w_adv;
    assign o_m_axis_tvalid = r_f_vld;
    assign o_m_axis_tdata  = OUT_W'({r_f_ovf, r_f_clamp, r_f_kept, r_f_next});

    // ---------------- checks
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_c_vld && !w_adv) |=> ($stable(r_c_len2) && r_c_vld))
        else $error("pipeline moved during stall");

    a_root_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_q_vld[NR-1] && r_q_base[NR-1].clamp) |-> (r_q_root[NR-1] != '0))
        else $error("zero length on clamped item");

    a_quo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_vld[P-1] && r_d_base[P-1].clamp) |->
        (r_d_quo[P-1][0] <= {r_lim_low, r_lim} && r_d_quo[P-1][1] <= {r_lim_low, r_lim}
         && r_d_quo[P-1][2] <= {r_lim_low, r_lim}))
        else $error("scaled coordinate beyond limit radius");

endmodule

// ===== bench/verlet_particle_step_sphere_bound_tb.sv =====
// Self-checking bench for verlet_particle_step_sphere_bound: directed and random particles,
// predicted results checked in order on the output stream. Depends on vpssb_pkg and the RTL.
module verlet_particle_step_sphere_bound_tb;
    import vpssb_pkg::*;

    localparam int PB = 22;
    localparam int IW = ((6*PB+7)/8)*8;
    localparam int OW = ((6*PB+2+7)/8)*8;
    localparam int LAT = 2*PB+7;

    typedef struct packed {
        logic [PB-1:0] nx, ny, nz, kx, ky, kz;
        logic          clamped, ovf;
    } t_step;

    logic          i_clk = 0, i_rst_n = 0;
    logic          i_cfg_we = 0;
    t_cfg_idx      i_cfg_idx = REG_LIMIT_RADIUS;
    logic [PB-1:0] i_cfg_data = '0;
    logic          i_s_axis_tvalid = 0;
    logic          o_s_axis_tready;
    logic [IW-1:0] i_s_axis_tdata = '0;
    logic          o_m_axis_tvalid;
    logic          i_m_axis_tready = 0;
    logic [OW-1:0] o_m_axis_tdata;

    verlet_particle_step_sphere_bound dut (.*);

    always #5 i_clk = ~i_clk;

    logic [IW-1:0] pending_q[$];
    t_step         step_q[$];
    logic [20:0]   radius = 21'(LIMIT_RESET);
    logic [21:0]   fall = 22'(FALL_RESET);
    int            errors = 0;
    bit            hold_rx = 0;

    function automatic longint sx(logic [PB-1:0] v);
        return longint'($signed(v));
    endfunction

    function automatic longint root64(longint unsigned n);
        longint unsigned r = 0, b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_step predict_step(logic [IW-1:0] d);
        longint p[3], pr[3], k[3], v, hi, lo;
        longint unsigned len2, lim, len, m;
        t_step s;
        logic [PB-1:0] nv[3];
        hi = (64'sd1 <<< (PB-1)) - 1;
        lo = -hi - 1;
        len2 = 0;
        s = '0;
        for (int i = 0; i < 3; i++) begin
            p[i] = sx(d[i*PB +: PB]);
            pr[i] = sx(d[(3+i)*PB +: PB]);
            m = p[i] < 0 ? -p[i] : p[i];
            len2 += m*m;
        end
        lim = radius;
        if (len2 > lim*lim) begin
            len = root64(len2);
            s.clamped = 1;
            for (int i = 0; i < 3; i++) begin
                m = p[i] < 0 ? -p[i] : p[i];
                m = (m*lim + (len >> 1)) / len;
                k[i] = p[i] < 0 ? -longint'(m) : longint'(m);
            end
        end else begin
            for (int i = 0; i < 3; i++) k[i] = p[i];
        end
        for (int i = 0; i < 3; i++) begin
            v = 2*k[i] - pr[i];
            if (i == 1) v += longint'($signed(fall));
            if (v > hi) begin v = hi; s.ovf = 1; end
            if (v < lo) begin v = lo; s.ovf = 1; end
            nv[i] = v[PB-1:0];
        end
        s.nx = nv[0]; s.ny = nv[1]; s.nz = nv[2];
        s.kx = k[0][PB-1:0]; s.ky = k[1][PB-1:0]; s.kz = k[2][PB-1:0];
        return s;
    endfunction

    function automatic int gap_len();
        int r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // sender
    int tx_gap = 0;
    always @(posedge i_clk) begin
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready) begin
            step_q.push_back(predict_step(i_s_axis_tdata));
        end
    end
    bit accepted;
    always @(posedge i_clk) accepted <= i_rst_n && i_s_axis_tvalid && o_s_axis_tready;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 0;
        end else if (i_s_axis_tvalid && !accepted) begin
        end else if (tx_gap > 0) begin
            tx_gap <= tx_gap - 1;
            i_s_axis_tvalid <= 0;
        end else if (pending_q.size() > 0) begin
            i_s_axis_tdata <= pending_q.pop_front();
            i_s_axis_tvalid <= 1;
            tx_gap <= gap_len();
        end else begin
            i_s_axis_tvalid <= 0;
        end
    end

    // receiver and checker
    always @(negedge i_clk) begin
        i_m_axis_tready <= !hold_rx && ($urandom_range(0, 99) < 70 || gap_len() == 0);
    end
    always @(posedge i_clk) begin
        t_step got, want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            got = {o_m_axis_tdata[0 +: PB], o_m_axis_tdata[PB +: PB],
                   o_m_axis_tdata[2*PB +: PB], o_m_axis_tdata[3*PB +: PB],
                   o_m_axis_tdata[4*PB +: PB], o_m_axis_tdata[5*PB +: PB],
                   o_m_axis_tdata[6*PB], o_m_axis_tdata[6*PB+1]};
            if (step_q.size() == 0) begin
                $error("unexpected result item %h", o_m_axis_tdata);
                errors++;
            end else begin
                want = step_q.pop_front();
                if (got.nx !== want.nx) begin
                    $error("next_x exp %h got %h", want.nx, got.nx); errors++;
                end
                if (got.ny !== want.ny) begin
                    $error("next_y exp %h got %h", want.ny, got.ny); errors++;
                end
                if (got.nz !== want.nz) begin
                    $error("next_z exp %h got %h", want.nz, got.nz); errors++;
                end
                if (got.kx !== want.kx) begin
                    $error("kept_x exp %h got %h", want.kx, got.kx); errors++;
                end
                if (got.ky !== want.ky) begin
                    $error("kept_y exp %h got %h", want.ky, got.ky); errors++;
                end
                if (got.kz !== want.kz) begin
                    $error("kept_z exp %h got %h", want.kz, got.kz); errors++;
                end
                if (got.clamped !== want.clamped) begin
                    $error("was_clamped exp %b got %b", want.clamped, got.clamped); errors++;
                end
                if (got.ovf !== want.ovf) begin
                    $error("overflowed exp %b got %b", want.ovf, got.ovf); errors++;
                end
            end
        end
    end

    function automatic logic [IW-1:0] pack_item(logic [PB-1:0] a, b, c, d, e, f);
        logic [IW-1:0] t = '0;
        t[6*PB-1:0] = {f, e, d, c, b, a};
        return t;
    endfunction

    function automatic logic [PB-1:0] rnd_coord(int span);
        int r = $urandom_range(0, 9);
        if (r == 0) return $urandom_range(0, 1) ? 22'h1FFFFF : 22'h200000;
        if (r < 4) return PB'($urandom());
        return PB'($signed($urandom_range(0, 2*span)) - span);
    endfunction

    task automatic wait_drained();
        while (pending_q.size() > 0 || i_s_axis_tvalid || step_q.size() > 0)
            @(posedge i_clk);
        repeat (LAT + 5) @(posedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [PB-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 0;
        @(posedge i_clk);
        if (idx == REG_LIMIT_RADIUS) radius = val[20:0];
        else fall = val;
    endtask

    task automatic random_phase(int n, int span);
        repeat (n) pending_q.push_back(pack_item(rnd_coord(span), rnd_coord(span),
            rnd_coord(span), rnd_coord(span), rnd_coord(span), rnd_coord(span)));
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1;
        // directed: origin, extremes, inside, on sphere, outside, saturation
        pending_q.push_back(pack_item('0, '0, '0, '0, '0, '0));
        pending_q.push_back(pack_item(22'h1FFFFF, 22'h1FFFFF, 22'h1FFFFF,
                                      22'h200000, 22'h200000, 22'h200000));
        pending_q.push_back(pack_item(22'h200000, 22'h200000, 22'h200000,
                                      22'h1FFFFF, 22'h1FFFFF, 22'h1FFFFF));
        pending_q.push_back(pack_item(22'd442368, '0, '0, '0, '0, '0));
        pending_q.push_back(pack_item(22'd442369, '0, '0, '0, '0, '0));
        pending_q.push_back(pack_item(PB'(-442368), '0, '0, '0, '0, '0));
        pending_q.push_back(pack_item(22'd65536, 22'd65536, 22'd65536, '0, '0, '0));
        pending_q.push_back(pack_item('0, 22'h200000, '0, '0, 22'h1FFFFF, '0));
        pending_q.push_back(pack_item('0, '0, 22'h1FFFFF, '0, '0, 22'h200000));
        random_phase(300, 600000);
        wait_drained();
        // output held off long; sender keeps going
        hold_rx = 1;
        random_phase(120, 600000);
        repeat (300) @(posedge i_clk);
        hold_rx = 0;
        wait_drained();
        write_reg(REG_LIMIT_RADIUS, '0);
        write_reg(REG_FALL_PER_STEP, 22'h1FFFFF);
        pending_q.push_back(pack_item(22'd1, '0, '0, '0, '0, '0));
        pending_q.push_back(pack_item('0, 22'h1FFFFF, '0, '0, 22'h200000, '0));
        random_phase(150, 2000000);
        wait_drained();
        write_reg(REG_LIMIT_RADIUS, 22'h1FFFFF);
        write_reg(REG_FALL_PER_STEP, 22'h200000);
        pending_q.push_back(pack_item('0, 22'h200000, '0, '0, 22'h1FFFFF, '0));
        random_phase(200, 2097152);
        wait_drained();
        write_reg(REG_LIMIT_RADIUS, PB'($urandom_range(1, 300000)));
        write_reg(REG_FALL_PER_STEP, PB'($urandom()));
        random_phase(250, 400000);
        wait_drained();
        if (errors == 0) $display("tb: success");
        else $display("tb: failure");
        $finish;
    end

    initial begin
        #3000000;
        $display("tb: failure");
        $finish;
    end
endmodule
